// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int BLK_W     = 11;
  localparam int CNT_W     = 12;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W    = 32;
  localparam int WBIT_W    = 5;
  localparam int BLK_MAX   = (1 << BLK_W) - 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  typedef logic [BLK_W-1:0]  blk_t;
  typedef logic [BLK_W:0]    blk_ext_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_NONE_FREE = 2'd1;
  localparam stat_t ST_RANGE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd2;

  localparam blk_t FIRST_RST = 11'd0;
  localparam blk_t LAST_RST  = 11'd1759;
  localparam blk_t ROOT_RST  = 11'd880;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator_top.sv =====
// Bitmap free-block allocator: word-wide free map in block RAM with a scan sequencer.
//
// Input stream in_*: one command per transfer (allocate, free, query). Result stream
// out_*: exactly one result per command, in order. Configuration: cfg_we writes
// first_block, last_block or root_block at cfg_index; write only while idle.
// Free and query of a usable block pass through the update state S_FQ, then S_DONE
// loads the result and raises out_tvalid; the next command is taken back in idle.
// Allocate reads one 32-bit map word per cycle through the single read port of the
// map memory, upward from above the root then downward below it, at most 65 words
// for 2048 blocks (the root's word is read in both directions). One command
// is in flight at a time; a new command is accepted while the previous result still
// waits on out_tready.
// After reset the map is cleared to all-allocated by a pass over every map word,
// during which in_tready stays low; the free count resets to zero.
// If the receiver stalls, the result holds in the output register and the next
// command finishes its work, then waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] cmd, [12:2] block_number
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [1:0] status, [12:2] allocated_block, [13] block_is_free, [25:14] free_count
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [BLK_W-1:0]      cfg_wdata
);

  localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAXB  = (NUM_BLOCKS - 1 < BLK_MAX) ? NUM_BLOCKS - 1 : BLK_MAX;
  localparam blk_ext_t MAXB_X = blk_ext_t'(MAXB);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FQ    = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  blk_t          first_r, last_r, root_r;
  cmd_t          cmd_r, cmd_nxt;
  blk_t          blk_r, blk_nxt;
  logic          phase_dn_r, phase_dn_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  cnt_t          free_total_r, free_total_nxt;
  stat_t         res_status_r, res_status_nxt;
  blk_t          res_alloc_r, res_alloc_nxt;
  logic          res_free_r, res_free_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  word_t         mem [WORDS];
  word_t         rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;

  cmd_t     in_cmd;
  blk_t     in_blk;
  blk_ext_t in_blk_x, first_p2, root_p1, root_m1, last_x, lim;
  blk_ext_t up_lo, up_hi, dn_lo, dn_hi, ph_lo, ph_hi;
  logic     up_ok, dn_ok, in_part, usable;
  logic [AW-1:0] lo_w, hi_w, up_lo_w, dn_hi_w;
  word_t    lo_mask, hi_mask, masked;
  logic [WBIT_W-1:0] pos;
  logic     hit, at_end, out_load;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_blk   = in_tdata[CMD_W+BLK_W-1:CMD_W];
  assign in_blk_x = {1'b0, in_blk};

  assign first_p2 = {1'b0, first_r} + blk_ext_t'(2);
  assign root_p1  = {1'b0, root_r} + blk_ext_t'(1);
  assign root_m1  = {1'b0, root_r} - blk_ext_t'(1);
  assign last_x   = {1'b0, last_r};
  assign lim      = (last_x < MAXB_X) ? last_x : MAXB_X;

  assign up_lo = (root_p1 > first_p2) ? root_p1 : first_p2;
  assign up_hi = lim;
  assign up_ok = (up_lo <= up_hi);
  assign dn_lo = first_p2;
  assign dn_hi = (root_m1 < lim) ? root_m1 : lim;
  assign dn_ok = (root_r != '0) && (dn_lo <= dn_hi);

  assign up_lo_w = AW'(up_lo >> WBIT_W);
  assign dn_hi_w = AW'(dn_hi >> WBIT_W);

  assign in_part = (in_blk_x >= {1'b0, first_r}) && (in_blk_x <= last_x) &&
                   (in_blk_x <= MAXB_X);
  assign usable  = in_part && (in_blk_x >= first_p2);

  assign ph_lo = phase_dn_r ? dn_lo : up_lo;
  assign ph_hi = phase_dn_r ? dn_hi : up_hi;
  assign lo_w  = AW'(ph_lo >> WBIT_W);
  assign hi_w  = AW'(ph_hi >> WBIT_W);

  assign lo_mask = (cur_r == lo_w) ? ({WORD_W{1'b1}} << ph_lo[WBIT_W-1:0]) : {WORD_W{1'b1}};
  assign hi_mask = (cur_r == hi_w) ?
                   ({WORD_W{1'b1}} >> (WBIT_W'(WORD_W - 1) - ph_hi[WBIT_W-1:0])) :
                   {WORD_W{1'b1}};
  assign masked  = rdata_r & lo_mask & hi_mask;
  assign hit     = (masked != '0);
  assign at_end  = phase_dn_r ? (cur_r == lo_w) : (cur_r == hi_w);

  always_comb begin
    pos = '0;
    if (phase_dn_r) begin
      for (int i = 0; i < WORD_W; i++) begin
        if (masked[i]) pos = WBIT_W'(i);
      end
    end else begin
      for (int i = WORD_W - 1; i >= 0; i--) begin
        if (masked[i]) pos = WBIT_W'(i);
      end
    end
  end

  assign out_load = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    blk_nxt        = blk_r;
    phase_dn_nxt   = phase_dn_r;
    cur_nxt        = cur_r;
    free_total_nxt = free_total_r;
    res_status_nxt = res_status_r;
    res_alloc_nxt  = res_alloc_r;
    res_free_nxt   = res_free_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = rdata_r;
    in_tready      = (state_r == S_IDLE);

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_WORD) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_cmd;
          blk_nxt        = in_blk;
          res_status_nxt = ST_OK;
          res_alloc_nxt  = '0;
          res_free_nxt   = 1'b0;
          state_nxt      = S_DONE;
          case (in_cmd)
            CMD_ALLOC: begin
              if (up_ok) begin
                rd_en        = 1'b1;
                rd_addr      = up_lo_w;
                cur_nxt      = up_lo_w;
                phase_dn_nxt = 1'b0;
                state_nxt    = S_SCAN;
              end else if (dn_ok) begin
                rd_en        = 1'b1;
                rd_addr      = dn_hi_w;
                cur_nxt      = dn_hi_w;
                phase_dn_nxt = 1'b1;
                state_nxt    = S_SCAN;
              end else begin
                res_status_nxt = ST_NONE_FREE;
              end
            end
            CMD_FREE, CMD_QUERY: begin
              if (!in_part) begin
                res_status_nxt = ST_RANGE;
              end else if (usable) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_blk >> WBIT_W);
                cur_nxt   = AW'(in_blk >> WBIT_W);
                state_nxt = S_FQ;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we         = 1'b1;
          mem_wdata      = rdata_r & ~(word_t'(1) << pos);
          free_total_nxt = free_total_r - cnt_t'(1);
          res_alloc_nxt  = BLK_W'({cur_r, pos});
          state_nxt      = S_DONE;
        end else if (!at_end) begin
          rd_en   = 1'b1;
          rd_addr = phase_dn_r ? (cur_r - AW'(1)) : (cur_r + AW'(1));
          cur_nxt = rd_addr;
        end else if (!phase_dn_r && dn_ok) begin
          rd_en        = 1'b1;
          rd_addr      = dn_hi_w;
          cur_nxt      = dn_hi_w;
          phase_dn_nxt = 1'b1;
        end else begin
          res_status_nxt = ST_NONE_FREE;
          state_nxt      = S_DONE;
        end
      end
      S_FQ: begin
        if (cmd_r == CMD_QUERY) begin
          res_free_nxt = rdata_r[blk_r[WBIT_W-1:0]];
        end else if (!rdata_r[blk_r[WBIT_W-1:0]]) begin
          mem_we         = 1'b1;
          mem_wdata      = rdata_r | (word_t'(1) << blk_r[WBIT_W-1:0]);
          free_total_nxt = free_total_r + cnt_t'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'd0, free_total_r, res_free_r, res_alloc_r, res_status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr];
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      free_total_r <= '0;
      out_tvalid_r <= 1'b0;
      first_r      <= FIRST_RST;
      last_r       <= LAST_RST;
      root_r       <= ROOT_RST;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      free_total_r <= free_total_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST: first_r <= cfg_wdata;
          CFG_LAST:  last_r  <= cfg_wdata;
          CFG_ROOT:  root_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    blk_r        <= blk_nxt;
    phase_dn_r   <= phase_dn_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_alloc_r  <= res_alloc_nxt;
    res_free_r   <= res_free_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_none_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_tdata_r[STAT_W-1:0] != ST_OK) |->
      (out_tdata_r[STAT_W+BLK_W-1:STAT_W] == '0))
    else $error("failed command reports a block number");

  a_free_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tdata_r[STAT_W+BLK_W] |->
      (out_tdata_r[STAT_W-1:0] == ST_OK))
    else $error("free answer on a failed command");

  a_count_follows_map: assert property (@(posedge clk) disable iff (!rst_n)
    (free_total_r != $past(free_total_r)) |-> $past(mem_we))
    else $error("free count moved without a map write");

  a_map_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR) || (state_r == S_SCAN) || (state_r == S_FQ))
    else $error("map write outside clear, scan or update");

endmodule

`default_nettype wire
